@@ rtl/fmlm_pkg.sv @@
// ----------------------------------------------------------------------------
// fmlm_pkg
// Shared types, codes and defaults of the FIFO mutex lock manager.
// ----------------------------------------------------------------------------
package fmlm_pkg;

  // Default sizes of the lock table, the wait queue and task identifiers
  localparam int unsigned DefNumLocks   = 64;
  localparam int unsigned DefWaitDepth  = 16;
  localparam int unsigned DefTaskIdBits = 16;

  // Fixed field widths of the request and response words
  localparam int unsigned OpW     = 1;
  localparam int unsigned LockIdW = 6;
  localparam int unsigned TaskIdW = 16;
  localparam int unsigned StatusW = 3;

  // Operation codes
  localparam logic [OpW-1:0] OP_CLAIM   = 1'b0;
  localparam logic [OpW-1:0] OP_RELEASE = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED   = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_BLOCKED   = 3'd2,
    ST_IDLED     = 3'd3,
    ST_HANDED    = 3'd4,
    ST_NOT_OWNER = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  // Command into the wait queue
  typedef struct packed {
    logic push;    // append the request at the tail
    logic remove;  // drop the oldest entry of the key lock and close the gap
  } q_cmd_t;

  // Status out of the wait queue for the key lock
  typedef struct packed {
    logic full;    // every cell holds a waiter
    logic hit;     // some waiter wants the key lock
    logic more;    // a second waiter wants the key lock
  } q_stat_t;

endpackage

@@ rtl/fmlm_if.sv @@
// ----------------------------------------------------------------------------
// fmlm_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface fmlm_req_if;
  logic                            valid;
  logic                            ready;
  logic [fmlm_pkg::OpW-1:0]        operation;
  logic [fmlm_pkg::LockIdW-1:0]    lock_id;
  logic [fmlm_pkg::TaskIdW-1:0]    task_id;

  modport source (output valid, operation, lock_id, task_id, input ready);
  modport sink   (input valid, operation, lock_id, task_id, output ready);
endinterface

interface fmlm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [fmlm_pkg::StatusW-1:0]    status;
  logic [fmlm_pkg::TaskIdW-1:0]    woken_task;
  logic                            lock_wanted;

  modport source (output valid, status, woken_task, lock_wanted, input ready);
  modport sink   (input valid, status, woken_task, lock_wanted, output ready);
endinterface

@@ rtl/fmlm_lock_table.sv @@
// ----------------------------------------------------------------------------
// fmlm_lock_table
// Per-lock memory of owned flag, wanted mark and owner, with a zeroing sweep
// after reset and a registered read port.
// ----------------------------------------------------------------------------
module fmlm_lock_table #(
  parameter int unsigned NUM_LOCKS    = fmlm_pkg::DefNumLocks,
  parameter int unsigned TASK_ID_BITS = fmlm_pkg::DefTaskIdBits,
  localparam int unsigned LockBits    = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1,
  localparam int unsigned EntryW      = TASK_ID_BITS + 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [LockBits-1:0] rd_addr_i,
  output logic [EntryW-1:0]   rd_data_o,
  input  logic                wr_en_i,
  input  logic [LockBits-1:0] wr_addr_i,
  input  logic [EntryW-1:0]   wr_data_i,
  output logic                busy_o
);

  logic [EntryW-1:0]   mem [NUM_LOCKS];
  logic [EntryW-1:0]   rd_q;
  logic [LockBits-1:0] clr_q, clr_d;
  logic                busy_q, busy_d;
  logic                we;
  logic [LockBits-1:0] wa;
  logic [EntryW-1:0]   wd;

  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + LockBits'(1);
      if (clr_q == LockBits'(NUM_LOCKS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  // Sweep zeros through the table before taking normal writes
  assign we = busy_q | wr_en_i;
  assign wa = busy_q ? clr_q : wr_addr_i;
  assign wd = busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

@@ rtl/fmlm_wait_cell.sv @@
// ----------------------------------------------------------------------------
// fmlm_wait_cell
// One slot of the wait queue: holds a lock and task pair, matches it against
// the key lock and takes its right neighbor's contents when the queue closes.
// ----------------------------------------------------------------------------
module fmlm_wait_cell #(
  parameter int unsigned LOCK_BITS = 6,
  parameter int unsigned TASK_BITS = fmlm_pkg::DefTaskIdBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fmlm_pkg::q_cmd_t     cmd_i,
  input  logic [LOCK_BITS-1:0] key_lock_i,
  input  logic [TASK_BITS-1:0] key_task_i,
  input  logic                 prev_valid_i,
  input  logic                 prev_seen_i,
  input  logic                 next_valid_i,
  input  logic [LOCK_BITS-1:0] next_lock_i,
  input  logic [TASK_BITS-1:0] next_task_i,
  output logic                 valid_o,
  output logic [LOCK_BITS-1:0] lock_o,
  output logic [TASK_BITS-1:0] task_o,
  output logic                 seen_o,
  output logic                 first_o,
  output logic                 extra_o
);

  logic                 valid_q, valid_d;
  logic [LOCK_BITS-1:0] lock_q, lock_d;
  logic [TASK_BITS-1:0] task_q, task_d;
  logic                 match;
  logic                 shift;
  logic                 load;

  assign match = valid_q && (lock_q == key_lock_i);
  // Shift left from the removed waiter onward; load the first free slot
  assign shift = cmd_i.remove && (prev_seen_i || match);
  assign load  = cmd_i.push && !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    lock_d  = lock_q;
    task_d  = task_q;
    if (shift) begin
      valid_d = next_valid_i;
      lock_d  = next_lock_i;
      task_d  = next_task_i;
    end else if (load) begin
      valid_d = 1'b1;
      lock_d  = key_lock_i;
      task_d  = key_task_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lock_q <= lock_d;
    task_q <= task_d;
  end

  assign valid_o = valid_q;
  assign lock_o  = lock_q;
  assign task_o  = task_q;
  assign seen_o  = prev_seen_i || match;
  assign first_o = match && !prev_seen_i;
  assign extra_o = match && prev_seen_i;

endmodule

@@ rtl/fmlm_wait_queue.sv @@
// ----------------------------------------------------------------------------
// fmlm_wait_queue
// Shared FIFO of waiting lock and task pairs built as a row of cells; finds
// the oldest waiter of a lock and closes the gap when it leaves.
// ----------------------------------------------------------------------------
module fmlm_wait_queue #(
  parameter int unsigned WAIT_DEPTH = fmlm_pkg::DefWaitDepth,
  parameter int unsigned LOCK_BITS  = 6,
  parameter int unsigned TASK_BITS  = fmlm_pkg::DefTaskIdBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fmlm_pkg::q_cmd_t     cmd_i,
  input  logic [LOCK_BITS-1:0] key_lock_i,
  input  logic [TASK_BITS-1:0] key_task_i,
  output fmlm_pkg::q_stat_t    stat_o,
  output logic [TASK_BITS-1:0] woken_o
);

  logic                 valid [WAIT_DEPTH];
  logic [LOCK_BITS-1:0] lock  [WAIT_DEPTH];
  logic [TASK_BITS-1:0] tsk   [WAIT_DEPTH];
  logic                 seen  [WAIT_DEPTH];
  logic [WAIT_DEPTH-1:0] first;
  logic [WAIT_DEPTH-1:0] extra;

  for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
    logic                 prev_valid;
    logic                 prev_seen;
    logic                 next_valid;
    logic [LOCK_BITS-1:0] next_lock;
    logic [TASK_BITS-1:0] next_task;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_seen  = 1'b0;
    end else begin : g_body
      assign prev_valid = valid[i-1];
      assign prev_seen  = seen[i-1];
    end

    if (i == WAIT_DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_lock  = '0;
      assign next_task  = '0;
    end else begin : g_link
      assign next_valid = valid[i+1];
      assign next_lock  = lock[i+1];
      assign next_task  = tsk[i+1];
    end

    fmlm_wait_cell #(
      .LOCK_BITS (LOCK_BITS),
      .TASK_BITS (TASK_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .key_lock_i   (key_lock_i),
      .key_task_i   (key_task_i),
      .prev_valid_i (prev_valid),
      .prev_seen_i  (prev_seen),
      .next_valid_i (next_valid),
      .next_lock_i  (next_lock),
      .next_task_i  (next_task),
      .valid_o      (valid[i]),
      .lock_o       (lock[i]),
      .task_o       (tsk[i]),
      .seen_o       (seen[i]),
      .first_o      (first[i]),
      .extra_o      (extra[i])
    );
  end

  // At most one cell flags first, so an OR of gated tasks picks it
  always_comb begin
    woken_o = '0;
    for (int unsigned i = 0; i < WAIT_DEPTH; i++) begin
      woken_o = woken_o | (first[i] ? tsk[i] : '0);
    end
  end

  assign stat_o.full = valid[WAIT_DEPTH-1];
  assign stat_o.hit  = seen[WAIT_DEPTH-1];
  assign stat_o.more = |extra;

endmodule

@@ rtl/fifo_mutex_lock_manager.sv @@
// ----------------------------------------------------------------------------
// fifo_mutex_lock_manager
// Hardware mutex table with one shared FIFO wait queue of lock and task pairs.
// ----------------------------------------------------------------------------
// A request word is taken in S_IDLE, which reads its lock's table entry;
// S_EXEC then matches and compacts the wait queue cells, writes the table
// back and loads the response register. No new request is taken until the
// last one leaves S_EXEC, which waits while a response is held. After reset
// the block sweeps zeros through every lock table entry and takes no request
// until then. A claim grants an unowned lock, returns already to its owner,
// and else queues the task behind the owner unless the queue is full. A
// release by the owner hands the lock to its oldest waiter or idles it.
module fifo_mutex_lock_manager #(
  parameter int unsigned NUM_LOCKS    = fmlm_pkg::DefNumLocks,
  parameter int unsigned WAIT_DEPTH   = fmlm_pkg::DefWaitDepth,
  parameter int unsigned TASK_ID_BITS = fmlm_pkg::DefTaskIdBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  fmlm_req_if.sink        req_i,
  fmlm_rsp_if.source      rsp_o
);

  localparam int unsigned LockBits = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int unsigned WideL    = (LockBits > fmlm_pkg::LockIdW) ?
                                     LockBits : fmlm_pkg::LockIdW;
  localparam int unsigned WideT    = (TASK_ID_BITS > fmlm_pkg::TaskIdW) ?
                                     TASK_ID_BITS : fmlm_pkg::TaskIdW;
  localparam int unsigned EntryW   = TASK_ID_BITS + 2;

  fmlm_pkg::state_e state_q, state_d;

  logic                          in_accept;
  logic                          commit;
  logic [WideL-1:0]              lk_wide;
  logic [WideT-1:0]              task_wide;
  logic [LockBits-1:0]           in_idx;
  logic [TASK_ID_BITS-1:0]       in_task;
  logic                          in_oor;

  logic [fmlm_pkg::OpW-1:0]      op_q;
  logic [LockBits-1:0]           idx_q;
  logic [TASK_ID_BITS-1:0]       task_q;
  logic                          oor_q;

  logic [EntryW-1:0]             rd_data;
  logic                          ent_owned;
  logic                          ent_wanted;
  logic [TASK_ID_BITS-1:0]       ent_owner;
  logic                          tbl_busy;
  logic                          wr_en;
  logic [EntryW-1:0]             wr_data;

  fmlm_pkg::q_cmd_t              q_cmd;
  fmlm_pkg::q_stat_t             q_stat;
  logic [TASK_ID_BITS-1:0]       q_woken;

  fmlm_pkg::status_e             st;
  logic [TASK_ID_BITS-1:0]       woken;
  logic                          wanted;
  logic [WideT-1:0]              woken_wide;

  logic                          out_valid_q, out_valid_d;
  logic [fmlm_pkg::StatusW-1:0]  out_status_q;
  logic [fmlm_pkg::TaskIdW-1:0]  out_woken_q;
  logic                          out_wanted_q;

  // Request decode
  assign lk_wide   = WideL'(req_i.lock_id);
  assign task_wide = WideT'(req_i.task_id);
  assign in_idx    = lk_wide[LockBits-1:0];
  assign in_task   = task_wide[TASK_ID_BITS-1:0];
  assign in_oor    = (32'(req_i.lock_id) >= 32'(NUM_LOCKS));

  assign req_i.ready = (state_q == fmlm_pkg::S_IDLE);
  assign in_accept   = req_i.valid && req_i.ready;
  assign commit      = (state_q == fmlm_pkg::S_EXEC) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      fmlm_pkg::S_CLEAR: if (!tbl_busy) state_d = fmlm_pkg::S_IDLE;
      fmlm_pkg::S_IDLE:  if (in_accept) state_d = fmlm_pkg::S_EXEC;
      fmlm_pkg::S_EXEC:  if (commit)    state_d = fmlm_pkg::S_IDLE;
      default:           state_d = fmlm_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmlm_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= req_i.operation;
      idx_q  <= in_idx;
      task_q <= in_task;
      oor_q  <= in_oor;
    end
  end

  fmlm_lock_table #(
    .NUM_LOCKS    (NUM_LOCKS),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (in_idx),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_q),
    .wr_data_i (wr_data),
    .busy_o    (tbl_busy)
  );

  assign ent_owned  = rd_data[EntryW-1];
  assign ent_wanted = rd_data[EntryW-2];
  assign ent_owner  = rd_data[TASK_ID_BITS-1:0];

  fmlm_wait_queue #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .LOCK_BITS  (LockBits),
    .TASK_BITS  (TASK_ID_BITS)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_cmd),
    .key_lock_i (idx_q),
    .key_task_i (task_q),
    .stat_o     (q_stat),
    .woken_o    (q_woken)
  );

  // Decide the outcome from the table entry and the queue match
  always_comb begin
    st      = fmlm_pkg::ST_NOT_OWNER;
    woken   = '0;
    wanted  = ent_wanted;
    wr_en   = 1'b0;
    wr_data = rd_data;
    q_cmd   = '0;
    if (oor_q) begin
      wanted = 1'b0;
    end else if (op_q == fmlm_pkg::OP_CLAIM) begin
      if (!ent_owned) begin
        st      = fmlm_pkg::ST_GRANTED;
        wanted  = 1'b0;
        wr_en   = commit;
        wr_data = {1'b1, 1'b0, task_q};
      end else if (ent_owner == task_q) begin
        st = fmlm_pkg::ST_ALREADY;
      end else if (q_stat.full) begin
        st = fmlm_pkg::ST_FULL;
      end else begin
        st           = fmlm_pkg::ST_BLOCKED;
        wanted       = 1'b1;
        wr_en        = commit;
        wr_data      = {1'b1, 1'b1, ent_owner};
        q_cmd.push   = commit;
      end
    end else begin
      if (!ent_owned || (ent_owner != task_q)) begin
        st = fmlm_pkg::ST_NOT_OWNER;
      end else if (!q_stat.hit) begin
        st      = fmlm_pkg::ST_IDLED;
        wanted  = 1'b0;
        wr_en   = commit;
        wr_data = '0;
      end else begin
        st           = fmlm_pkg::ST_HANDED;
        woken        = q_woken;
        wanted       = q_stat.more;
        wr_en        = commit;
        wr_data      = {1'b1, q_stat.more, q_woken};
        q_cmd.remove = commit;
      end
    end
  end

  assign woken_wide = WideT'(woken);

  // Response register: hold until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_status_q <= st;
      out_woken_q  <= woken_wide[fmlm_pkg::TaskIdW-1:0];
      out_wanted_q <= wanted;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.woken_task  = out_woken_q;
  assign rsp_o.lock_wanted = out_wanted_q;

endmodule

@@ tb/fmlm_lock_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmlm_lock_checker
// Watches the request and response channels of the lock manager, keeps its
// own lock table and wait list, and compares every response word in order.
// ----------------------------------------------------------------------------
module fmlm_lock_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  fmlm_req_if         req_i,
  fmlm_rsp_if         rsp_i,
  output int unsigned mismatch_o,
  output int unsigned pending_o
);

  typedef struct packed {
    fmlm_pkg::status_e              status;
    logic [fmlm_pkg::TaskIdW-1:0]   woken;
    logic                           wanted;
  } lock_outcome_t;

  typedef struct packed {
    logic [fmlm_pkg::LockIdW-1:0] lid;
    logic [fmlm_pkg::TaskIdW-1:0] tid;
  } waiter_t;

  logic                         lock_busy   [fmlm_pkg::DefNumLocks];
  logic [fmlm_pkg::TaskIdW-1:0] lock_holder [fmlm_pkg::DefNumLocks];
  logic                         want_mark   [fmlm_pkg::DefNumLocks];
  waiter_t                      waiters[$];
  lock_outcome_t                outcomes_due[$];
  int unsigned                  errs = 0;

  function automatic lock_outcome_t apply_lock_request(
    logic [fmlm_pkg::OpW-1:0]     op,
    logic [fmlm_pkg::LockIdW-1:0] lk,
    logic [fmlm_pkg::TaskIdW-1:0] tk
  );
    lock_outcome_t res;
    int            hit;
    logic          more;
    res = '{status: fmlm_pkg::ST_NOT_OWNER, woken: '0, wanted: 1'b0};
    if (lk >= fmlm_pkg::DefNumLocks) return res;
    if (op == fmlm_pkg::OP_CLAIM) begin
      if (!lock_busy[lk]) begin
        lock_busy[lk]   = 1'b1;
        lock_holder[lk] = tk;
        want_mark[lk]   = 1'b0;
        res.status      = fmlm_pkg::ST_GRANTED;
      end else if (lock_holder[lk] == tk) begin
        res.status = fmlm_pkg::ST_ALREADY;
        res.wanted = want_mark[lk];
      end else if (waiters.size() >= fmlm_pkg::DefWaitDepth) begin
        res.status = fmlm_pkg::ST_FULL;
        res.wanted = want_mark[lk];
      end else begin
        waiters.push_back('{lid: lk, tid: tk});
        want_mark[lk] = 1'b1;
        res.status    = fmlm_pkg::ST_BLOCKED;
        res.wanted    = 1'b1;
      end
    end else if (!lock_busy[lk] || lock_holder[lk] != tk) begin
      res.wanted = want_mark[lk];
    end else begin
      hit = -1;
      foreach (waiters[i]) if (hit < 0 && waiters[i].lid == lk) hit = i;
      if (hit < 0) begin
        lock_busy[lk]   = 1'b0;
        lock_holder[lk] = '0;
        want_mark[lk]   = 1'b0;
        res.status      = fmlm_pkg::ST_IDLED;
      end else begin
        // hand over to the oldest waiter and close the gap
        res.woken = waiters[hit].tid;
        waiters.delete(hit);
        more = 1'b0;
        foreach (waiters[i]) if (waiters[i].lid == lk) more = 1'b1;
        lock_holder[lk] = res.woken;
        want_mark[lk]   = more;
        res.status      = fmlm_pkg::ST_HANDED;
        res.wanted      = more;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lock_outcome_t got;
    lock_outcome_t want;
    if (!rst_ni) begin
      foreach (lock_busy[i]) begin
        lock_busy[i]   = 1'b0;
        lock_holder[i] = '0;
        want_mark[i]   = 1'b0;
      end
      waiters.delete();
      outcomes_due.delete();
      errs = 0;
      mismatch_o <= 0;
      pending_o  <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{status: fmlm_pkg::status_e'(rsp_i.status), woken: rsp_i.woken_task,
                wanted: rsp_i.lock_wanted};
        if (outcomes_due.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("t=%0t lock response with none due: status %0d woken %h wanted %b",
                     $time, got.status, got.woken, got.wanted);
        end else begin
          want = outcomes_due.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10)
              $display("t=%0t lock response: expected status %0d woken %h wanted %b,",
                       $time, want.status, want.woken, want.wanted,
                       " got status %0d woken %h wanted %b",
                       got.status, got.woken, got.wanted);
          end
        end
      end
      if (req_i.valid && req_i.ready)
        outcomes_due.push_back(apply_lock_request(req_i.operation, req_i.lock_id,
                                                  req_i.task_id));
      mismatch_o <= errs;
      pending_o  <= outcomes_due.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives claim and release words into the lock manager with random gaps and
// response stalls, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned TotalItems  = 1150;
  localparam int unsigned WatchLimit  = 2000;
  localparam int unsigned DrainCycles = 20;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned idle_cycles;
  int unsigned sent_count;
  bit          quiet_send;
  bit          quiet_recv;

  logic [fmlm_pkg::TaskIdW-1:0] team [5];
  logic [fmlm_pkg::LockIdW-1:0] hot  [8];

  fmlm_req_if req_ch ();
  fmlm_rsp_if rsp_ch ();

  fifo_mutex_lock_manager dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  fmlm_lock_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rsp_i      (rsp_ch),
    .mismatch_o (mismatch_cnt),
    .pending_o  (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("fifo_mutex_lock_manager: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // response side: stall a random number of cycles before each word
  initial begin
    int n;
    rsp_ch.ready <= 1'b0;
    quiet_recv = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet_recv = !quiet_recv;
      n = quiet_recv ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  task automatic send_word(input logic [fmlm_pkg::OpW-1:0] op,
                           input logic [fmlm_pkg::LockIdW-1:0] lk,
                           input logic [fmlm_pkg::TaskIdW-1:0] tk);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.lock_id   <= lk;
    req_ch.task_id   <= tk;
    do @(posedge clk_i); while (!req_ch.ready);
    sent_count++;
  endtask

  // hold off until every response word has come back
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  task automatic contention_phase();
    int                           len;
    int                           claim_pct;
    int                           nlocks;
    int                           base;
    int                           r;
    bit                           hit;
    logic [fmlm_pkg::LockIdW-1:0] lk;
    logic [fmlm_pkg::OpW-1:0]     op;
    len        = $urandom_range(20, 60);
    claim_pct  = $urandom_range(20, 80);
    nlocks     = $urandom_range(2, 4);
    base       = $urandom_range(0, 7);
    quiet_send = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // claim a lock outside the contended set, then release it as a random task
        do begin
          lk  = fmlm_pkg::LockIdW'($urandom);
          hit = 1'b0;
          foreach (hot[j]) if (hot[j] == lk) hit = 1'b1;
        end while (hit);
        send_word(fmlm_pkg::OP_CLAIM, lk, fmlm_pkg::TaskIdW'($urandom));
        send_word(fmlm_pkg::OP_RELEASE, lk, fmlm_pkg::TaskIdW'($urandom));
      end else if (r < 14) begin
        send_word(fmlm_pkg::OP_RELEASE, fmlm_pkg::LockIdW'($urandom),
                  fmlm_pkg::TaskIdW'($urandom));
      end else begin
        op = ($urandom_range(0, 99) < claim_pct) ? fmlm_pkg::OP_CLAIM
                                                 : fmlm_pkg::OP_RELEASE;
        send_word(op, hot[(base + $urandom_range(0, nlocks - 1)) % 8],
                  team[$urandom_range(0, 4)]);
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= fmlm_pkg::OP_CLAIM;
    req_ch.lock_id   <= '0;
    req_ch.task_id   <= '0;
    sent_count = 0;
    quiet_send = 1'b0;
    team[0] = '0;
    team[1] = '1;
    for (int k = 2; k < 5; k++) team[k] = fmlm_pkg::TaskIdW'($urandom);
    hot[0] = '0;
    hot[1] = '1;
    hot[2] = fmlm_pkg::LockIdW'(42);
    for (int k = 3; k < 8; k++) hot[k] = fmlm_pkg::LockIdW'($urandom_range(1, 62));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // release of an idle lock, grant, repeated claim by the owner
    send_word(fmlm_pkg::OP_RELEASE, hot[0], team[0]);
    send_word(fmlm_pkg::OP_CLAIM, hot[1], team[0]);
    send_word(fmlm_pkg::OP_CLAIM, hot[1], team[0]);
    send_word(fmlm_pkg::OP_CLAIM, hot[0], team[1]);
    // fill the wait list with interleaved waiters, repeats included
    for (int k = 0; k < 16; k++)
      send_word(fmlm_pkg::OP_CLAIM, (k % 2) ? hot[0] : hot[1], team[2 + k % 3]);
    send_word(fmlm_pkg::OP_CLAIM, hot[0], team[3]);
    send_word(fmlm_pkg::OP_RELEASE, hot[0], team[2]);
    send_word(fmlm_pkg::OP_RELEASE, hot[0], team[1]);
    send_word(fmlm_pkg::OP_CLAIM, hot[2], team[4]);
    send_word(fmlm_pkg::OP_RELEASE, hot[2], team[4]);
    send_word(fmlm_pkg::OP_RELEASE, hot[1], team[0]);
    wait_for_drain();

    while (sent_count < TotalItems) begin
      contention_phase();
      if ($urandom_range(0, 2) == 0) wait_for_drain();
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("fifo_mutex_lock_manager: match");
    end else begin
      $display("fifo_mutex_lock_manager: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fmlm_pkg.sv
rtl/fmlm_if.sv
rtl/fmlm_lock_table.sv
rtl/fmlm_wait_cell.sv
rtl/fmlm_wait_queue.sv
rtl/fifo_mutex_lock_manager.sv
tb/fmlm_lock_checker.sv
tb/tb.sv
